[src/scfd_pkg.sv]
// ----------------------------------------------------------------------------
// Serial command field decoder package
// Command codes, target numbers and widths shared by the decoder.
// ----------------------------------------------------------------------------
package scfd_pkg;

  localparam int ByteW   = 8;
  localparam int TargetW = 5;
  localparam int ValueW  = 12;

  localparam logic [ByteW-1:0] CodeIdle = 8'h00;
  localparam logic [ByteW-1:0] CodeA0   = 8'hA0;
  localparam logic [ByteW-1:0] CodeA5   = 8'hA5;
  localparam logic [ByteW-1:0] CodeB0   = 8'hB0;
  localparam logic [ByteW-1:0] CodeB1   = 8'hB1;
  localparam logic [ByteW-1:0] CodeB4   = 8'hB4;
  localparam logic [ByteW-1:0] CodeC0   = 8'hC0;
  localparam logic [ByteW-1:0] CodeC5   = 8'hC5;
  localparam logic [ByteW-1:0] CodeD0   = 8'hD0;
  localparam logic [ByteW-1:0] CodeD1   = 8'hD1;

  localparam logic [TargetW-1:0] TgtDisplay = 5'd6;
  localparam logic [TargetW-1:0] TgtYear    = 5'd11;
  localparam logic [TargetW-1:0] TgtServer  = 5'd17;

  localparam logic [ValueW-1:0] YearBase = 12'd2000;

  typedef struct packed {
    logic               write_valid;
    logic [TargetW-1:0] target;
    logic [ValueW-1:0]  value;
    logic [ByteW-1:0]   server_index;
  } result_t;

endpackage

[src/serial_command_field_decoder.sv]
// ----------------------------------------------------------------------------
// Serial command field decoder
// Decodes received bytes into writes to named target fields, one result per
// byte. An input register and a result register bracket the decode logic.
// The input byte is registered, then decoded into the result register, which
// holds while out_valid is high and out_ready is low. Throughput: one byte per
// cycle unless out_ready stalls it; the decode and command state update are a
// single short case decode between the input and result registers.
// Reset: clears the command state to idle, the pending index to zero and
// both stage valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module serial_command_field_decoder
  import scfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ByteW-1:0]   rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               write_valid,
  output logic [TargetW-1:0] target,
  output logic [ValueW-1:0]  value,
  output logic [ByteW-1:0]   server_index
);

  logic             in_reg_valid;
  logic [ByteW-1:0] in_reg_byte;
  logic [ByteW-1:0] command_state;
  logic [ByteW-1:0] command_state_next;
  logic [ByteW-1:0] pending_index;
  logic [ByteW-1:0] pending_index_next;
  logic             advance;
  result_t          result;
  result_t          result_next;

  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  always_comb begin
    command_state_next = CodeIdle;
    pending_index_next = pending_index;
    result_next        = '0;
    case (command_state) inside
      CodeIdle: begin
        command_state_next = in_reg_byte;
      end
      [CodeA0:CodeA5]: begin
        result_next.write_valid = 1'b1;
        result_next.target      = TargetW'(command_state - CodeA0);
        result_next.value       = {4'd0, in_reg_byte};
        command_state_next      = (command_state == CodeA5) ? CodeIdle :
                                  command_state + 8'd1;
      end
      [CodeB0:CodeB4]: begin
        result_next.write_valid = 1'b1;
        result_next.target      = TgtDisplay + TargetW'(command_state - CodeB0);
        result_next.value       = {4'd0, in_reg_byte};
        command_state_next      = (command_state == CodeB0 || command_state == CodeB4) ?
                                  CodeIdle : command_state + 8'd1;
      end
      [CodeC0:CodeC5]: begin
        result_next.write_valid = 1'b1;
        result_next.target      = TgtYear + TargetW'(command_state - CodeC0);
        result_next.value       = (command_state == CodeC0) ?
                                  YearBase + {4'd0, in_reg_byte} : {4'd0, in_reg_byte};
        command_state_next      = (command_state == CodeC5) ? CodeIdle :
                                  command_state + 8'd1;
      end
      CodeD0: begin
        pending_index_next = in_reg_byte;
        command_state_next = CodeD1;
      end
      CodeD1: begin
        result_next.write_valid  = 1'b1;
        result_next.target       = TgtServer;
        result_next.value        = {4'd0, in_reg_byte};
        result_next.server_index = pending_index;
      end
      default: begin
        command_state_next = CodeIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid  <= 1'b0;
      out_valid     <= 1'b0;
      command_state <= CodeIdle;
      pending_index <= '0;
    end else begin
      if (in_ready) begin
        in_reg_valid <= in_valid;
      end
      if (advance) begin
        out_valid     <= 1'b1;
        command_state <= command_state_next;
        pending_index <= pending_index_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_reg_byte <= rx_byte;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign write_valid  = result.write_valid;
  assign target       = result.target;
  assign value        = result.value;
  assign server_index = result.server_index;

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid after reset.");

  a_idle_output_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input stalled while the result register is empty.");

  a_no_write_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> target == '0 && value == '0 && server_index == '0)
    else $error("A result without a write carries nonzero fields.");

  a_index_only_for_server: assert property (@(posedge clk) disable iff (rst)
    out_valid && server_index != '0 |-> write_valid && target == TgtServer)
    else $error("Server index set on a write to another target.");

  a_year_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid && target == TgtYear |-> value >= YearBase)
    else $error("Year write lacks its base offset.");

endmodule
